>>> sv/cqap_pkg.sv
// Shared types, constants and helpers of the command queue with argument parser.
package cqap_pkg;

  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned MaxArgs      = 2;
  localparam int unsigned ArgBufferLen = 20;
  localparam int unsigned MaxResults   = 4;

  localparam int unsigned IdxW    = $clog2(QueueDepth);
  localparam int unsigned CntW    = $clog2(MaxArgs + 1);
  localparam int unsigned ArgIdxW = (MaxArgs > 1) ? $clog2(MaxArgs) : 1;
  localparam int unsigned CharW   = $clog2(ArgBufferLen);
  localparam int unsigned ResCntW = $clog2(MaxResults);

  localparam logic [7:0] EscChar   = 8'h1B;
  localparam logic [7:0] CommaChar = 8'h2C;
  localparam logic [7:0] NlChar    = 8'h0A;
  localparam logic [7:0] CrChar    = 8'h0D;
  localparam logic [7:0] SpaceChar = 8'h20;
  localparam logic [7:0] TabChar   = 8'h09;
  localparam logic [7:0] VtChar    = 8'h0B;
  localparam logic [7:0] FfChar    = 8'h0C;
  localparam logic [7:0] PlusChar  = 8'h2B;
  localparam logic [7:0] MinusChar = 8'h2D;
  localparam logic [7:0] ZeroChar  = 8'h30;
  localparam logic [7:0] NineChar  = 8'h39;

  typedef enum logic [1:0] {
    OpEnqueue = 2'd0,
    OpArgChar = 2'd1,
    OpRun     = 2'd2,
    OpUnused  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    KindDispatch = 3'd0,
    KindTaken    = 3'd1,
    KindIgnored  = 3'd2,
    KindEnqueued = 3'd3,
    KindTooMany  = 3'd4,
    KindFull     = 3'd5,
    KindRunDone  = 3'd6
  } kind_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] command_code;
    logic [7:0] handler_id;
    logic [7:0] arg_count;
    logic [7:0] arg_char;
  } in_t;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         out_command;
    logic [7:0]         out_handler;
    logic [1:0]         out_arg_count;
    logic signed [15:0] first_arg;
    logic signed [15:0] second_arg;
    logic               last;
  } out_t;

  typedef struct packed {
    logic  load;
    logic  emit;
    kind_e kind;
    logic  last;
    logic  dispatch;
    logic  enqueue;
    logic  char_step;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       too_many;
    logic       full;
    logic       empty;
    logic       char_ignored;
    logic       head_ready;
  } dp_status_t;

  function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] idx);
    if (idx == IdxW'(QueueDepth - 1)) begin
      return '0;
    end
    return idx + 1'b1;
  endfunction

endpackage

>>> sv/cqap_datapath.sv
// Datapath: entry storage, ring pointers, argument parser and result register.
module cqap_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cqap_pkg::in_t        item_i,
  input  cqap_pkg::dp_cmd_t    cmd_i,
  output cqap_pkg::dp_status_t status_o,
  output cqap_pkg::out_t       result_o,
  output logic                 result_valid_o
);

  typedef enum logic [1:0] {
    PhSkip    = 2'd0,
    PhNumber  = 2'd1,
    PhStopped = 2'd2
  } phase_e;

  cqap_pkg::in_t item_q;

  logic [cqap_pkg::IdxW-1:0] head_q, tail_q, fill_q;
  logic [cqap_pkg::CntW-1:0] fill_rcv_q, fill_exp_q;
  logic [cqap_pkg::CharW-1:0] chars_q;
  logic [15:0] value_q;
  phase_e      phase_q;
  logic        neg_q;

  cqap_pkg::out_t result_q;
  logic           valid_q;

  logic [7:0]                mem_cmd [cqap_pkg::QueueDepth];
  logic [7:0]                mem_hnd [cqap_pkg::QueueDepth];
  logic [cqap_pkg::CntW-1:0] mem_exp [cqap_pkg::QueueDepth];
  logic [cqap_pkg::CntW-1:0] mem_rcv [cqap_pkg::QueueDepth];
  logic [15:0]               mem_val [cqap_pkg::QueueDepth][cqap_pkg::MaxArgs];

  logic [7:0]                rd_cmd_q, rd_hnd_q;
  logic [cqap_pkg::CntW-1:0] rd_exp_q, rd_rcv_q;
  logic [15:0]               rd_val_q [cqap_pkg::MaxArgs];

  // Parser combinational step
  logic [7:0]  c;
  logic        is_term, is_space, is_sign, is_digit, limit_hit, finish;
  logic [15:0] value_mul, pv, arg_v;
  logic        pn;
  phase_e      pph;

  assign c         = item_q.arg_char;
  assign is_term   = (c == cqap_pkg::NlChar) || (c == cqap_pkg::CrChar) ||
                     (c == cqap_pkg::CommaChar) || (c == cqap_pkg::EscChar);
  assign is_space  = (c == cqap_pkg::SpaceChar) || (c == cqap_pkg::TabChar) ||
                     (c == cqap_pkg::VtChar) || (c == cqap_pkg::FfChar);
  assign is_sign   = (c == cqap_pkg::PlusChar) || (c == cqap_pkg::MinusChar);
  assign is_digit  = (c >= cqap_pkg::ZeroChar) && (c <= cqap_pkg::NineChar);
  assign value_mul = {value_q[12:0], 3'b000} + {value_q[14:0], 1'b0} + {12'd0, c[3:0]};

  always_comb begin
    pv  = value_q;
    pn  = neg_q;
    pph = phase_q;
    unique case (phase_q)
      PhSkip: begin
        if (is_space) begin
          pph = PhSkip;
        end else if (is_sign) begin
          pn  = (c == cqap_pkg::MinusChar);
          pph = PhNumber;
        end else if (is_digit) begin
          pv  = value_mul;
          pph = PhNumber;
        end else begin
          pph = PhStopped;
        end
      end
      PhNumber: begin
        if (is_digit) begin
          pv = value_mul;
        end else begin
          pph = PhStopped;
        end
      end
      default: begin
        pph = phase_q;
      end
    endcase
  end

  // Terminators close the argument as it stands; the length limit closes it after this char
  assign limit_hit = ({1'b0, chars_q} + (cqap_pkg::CharW + 1)'(2)) >=
                     (cqap_pkg::CharW + 1)'(cqap_pkg::ArgBufferLen);
  assign finish    = is_term || limit_hit;
  assign arg_v     = is_term ? (neg_q ? 16'd0 - value_q : value_q)
                             : (pn ? 16'd0 - pv : pv);

  assign status_o.opcode       = item_q.opcode;
  assign status_o.too_many     = item_q.arg_count > 8'(cqap_pkg::MaxArgs);
  assign status_o.full         = cqap_pkg::ring_next(tail_q) == head_q;
  assign status_o.empty        = head_q == tail_q;
  assign status_o.char_ignored = (head_q == tail_q) ||
                                 (fill_rcv_q >= cqap_pkg::CntW'(cqap_pkg::MaxArgs)) ||
                                 (fill_rcv_q >= fill_exp_q);
  assign status_o.head_ready   = (rd_rcv_q == rd_exp_q) && (rd_hnd_q != 8'd0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  // Entry storage: one write per cycle, head read registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.enqueue) begin
      mem_cmd[tail_q] <= item_q.command_code;
      mem_hnd[tail_q] <= item_q.handler_id;
      mem_exp[tail_q] <= item_q.arg_count[cqap_pkg::CntW-1:0];
      mem_rcv[tail_q] <= '0;
    end else if (cmd_i.char_step && finish &&
                 (fill_rcv_q < cqap_pkg::CntW'(cqap_pkg::MaxArgs))) begin
      mem_val[fill_q][fill_rcv_q[cqap_pkg::ArgIdxW-1:0]] <= arg_v;
      mem_rcv[fill_q] <= fill_rcv_q + 1'b1;
    end
    rd_cmd_q <= mem_cmd[head_q];
    rd_hnd_q <= mem_hnd[head_q];
    rd_exp_q <= mem_exp[head_q];
    rd_rcv_q <= mem_rcv[head_q];
    rd_val_q <= mem_val[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      fill_q     <= '0;
      fill_rcv_q <= '0;
      fill_exp_q <= '0;
      chars_q    <= '0;
      value_q    <= '0;
      phase_q    <= PhSkip;
      neg_q      <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
      if (cmd_i.dispatch) begin
        head_q <= cqap_pkg::ring_next(head_q);
      end
      if (cmd_i.enqueue) begin
        fill_q     <= tail_q;
        tail_q     <= cqap_pkg::ring_next(tail_q);
        fill_rcv_q <= '0;
        fill_exp_q <= item_q.arg_count[cqap_pkg::CntW-1:0];
      end
      if (cmd_i.char_step) begin
        if (finish) begin
          if (fill_rcv_q < cqap_pkg::CntW'(cqap_pkg::MaxArgs)) begin
            fill_rcv_q <= fill_rcv_q + 1'b1;
          end
          chars_q <= '0;
          value_q <= '0;
          phase_q <= PhSkip;
          neg_q   <= 1'b0;
        end else begin
          chars_q <= chars_q + 1'b1;
          value_q <= pv;
          phase_q <= pph;
          neg_q   <= pn;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_q.kind          <= cmd_i.kind;
      result_q.last          <= cmd_i.last;
      result_q.out_command   <= 8'd0;
      result_q.out_handler   <= 8'd0;
      result_q.out_arg_count <= 2'd0;
      result_q.first_arg     <= 16'sd0;
      result_q.second_arg    <= 16'sd0;
      case (cmd_i.kind) inside
        cqap_pkg::KindDispatch: begin
          result_q.out_command   <= rd_cmd_q;
          result_q.out_handler   <= rd_hnd_q;
          result_q.out_arg_count <= 2'(rd_exp_q);
          if ({1'b0, rd_exp_q} >= (cqap_pkg::CntW + 1)'(1)) begin
            result_q.first_arg <= rd_val_q[0];
          end
          if ((cqap_pkg::MaxArgs >= 2) &&
              ({1'b0, rd_exp_q} >= (cqap_pkg::CntW + 1)'(2))) begin
            result_q.second_arg <= rd_val_q[cqap_pkg::MaxArgs-1];
          end
        end
        cqap_pkg::KindEnqueued, cqap_pkg::KindTooMany, cqap_pkg::KindFull: begin
          result_q.out_command <= item_q.command_code;
        end
        default: begin
          result_q.out_command <= 8'd0;
        end
      endcase
    end
  end

  assign result_o       = result_q;
  assign result_valid_o = valid_q;

endmodule

>>> sv/cqap_ctrl.sv
// Controller: sequences one item through decode, queue run and final status.
module cqap_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  cqap_pkg::dp_status_t status_i,
  output cqap_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StRunRead,
    StRunCheck,
    StPost
  } state_e;

  state_e                       state_q, state_d;
  logic                         busy_q, busy_d;
  logic [cqap_pkg::ResCntW-1:0] nres_q, nres_d;

  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    nres_d  = nres_q;
    cmd_o   = '0;
    cmd_o.kind = cqap_pkg::KindRunDone;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          busy_d     = 1'b1;
          nres_d     = '0;
          state_d    = StExec;
        end
      end
      StExec: begin
        unique case (status_i.opcode)
          cqap_pkg::OpEnqueue: begin
            if (status_i.too_many) begin
              cmd_o.emit = 1'b1;
              cmd_o.kind = cqap_pkg::KindTooMany;
              cmd_o.last = 1'b1;
              busy_d     = 1'b0;
              state_d    = StIdle;
            end else if (status_i.full) begin
              state_d = StRunRead;
            end else begin
              state_d = StPost;
            end
          end
          cqap_pkg::OpArgChar: begin
            cmd_o.emit      = 1'b1;
            cmd_o.last      = 1'b1;
            cmd_o.kind      = status_i.char_ignored ? cqap_pkg::KindIgnored
                                                    : cqap_pkg::KindTaken;
            cmd_o.char_step = !status_i.char_ignored;
            busy_d          = 1'b0;
            state_d         = StIdle;
          end
          cqap_pkg::OpRun: begin
            state_d = StRunRead;
          end
          default: begin
            busy_d  = 1'b0;
            state_d = StIdle;
          end
        endcase
      end
      // Wait here after each head move so that the registered head read follows the new head
      StRunRead: begin
        state_d = StRunCheck;
      end
      StRunCheck: begin
        if (!status_i.empty && status_i.head_ready &&
            (nres_q != cqap_pkg::ResCntW'(cqap_pkg::MaxResults - 1))) begin
          cmd_o.emit     = 1'b1;
          cmd_o.kind     = cqap_pkg::KindDispatch;
          cmd_o.dispatch = 1'b1;
          nres_d         = nres_q + 1'b1;
          state_d        = StRunRead;
        end else begin
          state_d = StPost;
        end
      end
      StPost: begin
        cmd_o.emit = 1'b1;
        cmd_o.last = 1'b1;
        if (status_i.opcode == cqap_pkg::OpRun) begin
          cmd_o.kind = cqap_pkg::KindRunDone;
        end else if (status_i.full) begin
          cmd_o.kind = cqap_pkg::KindFull;
        end else begin
          cmd_o.kind    = cqap_pkg::KindEnqueued;
          cmd_o.enqueue = 1'b1;
        end
        busy_d  = 1'b0;
        state_d = StIdle;
      end
      default: begin
        busy_d  = 1'b0;
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q  <= 1'b0;
      nres_q  <= '0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      nres_q  <= nres_d;
    end
  end

  assign busy = busy_q;

endmodule

>>> sv/command_queue_with_arg_parser_top.sv
// Top level of the command queue with argument parser: controller plus datapath.
// An argument char or an enqueue with too many arguments is answered as busy drops.
// An enqueue with room answers from the post state; a run passes through the read and
// check states once per dispatched word (registered head read), then the post state.
// Results are single-cycle strobes and cannot be stalled; busy alone paces the sender.
// Reset (rst_ni low, asynchronous) empties the ring and clears the parser; no clearing pass.
module command_queue_with_arg_parser_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  cqap_pkg::in_t  item_i,
  output logic           result_valid_o,
  output cqap_pkg::out_t result_o
);

  cqap_pkg::dp_cmd_t    dp_cmd;
  cqap_pkg::dp_status_t dp_status;

  cqap_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (dp_status),
    .cmd_o    (dp_cmd)
  );

  cqap_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule
